FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only.
`define ASSERT_RESET(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: hdl/lspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip pattern generator package
// Shared widths, mode and register codes, and the color wheel function.
// ----------------------------------------------------------------------------
package lspg_pkg;

   localparam int MAX_LEDS_DEF = 64;
   localparam int IDX_W        = 6;
   localparam int COLOR_W      = 24;
   localparam int MODE_W       = 3;
   localparam int INTERVAL_W   = 16;
   localparam int DURATION_W   = 24;
   localparam int COUNT_W      = 7;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   typedef logic [COLOR_W-1:0]    color_type;
   typedef logic [IDX_W-1:0]      pixel_idx_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WIPE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd4;

   localparam csr_idx_type REG_MODE     = 3'd0;
   localparam csr_idx_type REG_COLOR    = 3'd1;
   localparam csr_idx_type REG_INTERVAL = 3'd2;
   localparam csr_idx_type REG_DURATION = 3'd3;
   localparam csr_idx_type REG_COUNT    = 3'd4;

   localparam logic [7:0] FADE_STEP   = 8'd5;
   localparam logic [7:0] LEVEL_MAX   = 8'd255;
   localparam logic [7:0] WHEEL_SEG1  = 8'd85;
   localparam logic [7:0] WHEEL_SEG2  = 8'd170;

   // Three-segment color wheel, red -> green -> blue -> red.
   function automatic color_type wheel_color(input logic [7:0] pos);
      logic [7:0] p;
      logic [7:0] s;
      logic [7:0] t;
      color_type  c;
      p = LEVEL_MAX - pos;
      if (p < WHEEL_SEG1) begin
         t = 8'((p << 1) + p);
         c = {LEVEL_MAX - t, 8'd0, t};
      end else if (p < WHEEL_SEG2) begin
         s = p - WHEEL_SEG1;
         t = 8'((s << 1) + s);
         c = {8'd0, t, LEVEL_MAX - t};
      end else begin
         s = p - WHEEL_SEG2;
         t = 8'((s << 1) + s);
         c = {t, LEVEL_MAX - t, 8'd0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/lspg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip pattern generator channels
// Tick request channel and pixel response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lspg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface lspg_rsp_if;
   import lspg_pkg::*;
   logic          valid;
   logic          ready;
   pixel_idx_type pixel_index;
   color_type     pixel_color;
   logic          frame_last;

   modport source (output valid, output pixel_index, output pixel_color,
                   output frame_last, input ready);
   modport sink   (input valid, input pixel_index, input pixel_color,
                   input frame_last, output ready);
endinterface
`default_nettype wire

FILE: hdl/led_strip_pattern_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip pattern generator
// Counts millisecond ticks and, when a frame is due, updates the frame
// store and streams every active pixel on the response channel.
//
// req_if carries one tick per beat; restart clears the run timer. rsp_if
// carries one pixel per beat, pixel_index 0 up to the LED count (held to
// 1 .. MAX_LEDS) minus one, with frame_last on the final pixel. csr_* writes
// one register per cycle; the user must write only while the block is idle,
// which the block itself does not enforce. A tick that starts no frame
// passes tick capture and timer compare only. A frame tick passes tick
// capture, timer compare, pattern update, a 9-step restoring divider for the
// rainbow spacing (256 / N), then issues one pixel per cycle through the
// frame store port while the receiver does not stall.
// The frame store is a single-port RAM with a registered read; a row
// of valid bits makes never written entries read as off.
// Reset clears timers, pattern state, valid bits and both channels at once;
// no clearing pass. A stalled receiver holds the output register and a
// one-deep staging register; the sequencer waits and no pixel is lost.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator_top #(
   parameter int MAX_LEDS = lspg_pkg::MAX_LEDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lspg_req_if.sink                    req_if,
   lspg_rsp_if.source                  rsp_if,
   input  wire logic                   csr_wr_en,
   input  wire lspg_pkg::csr_idx_type  csr_index,
   input  wire lspg_pkg::csr_data_type csr_wr_data
);
   import lspg_pkg::*;

   localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CNT_W  = $clog2(MAX_LEDS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVAL  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam logic [3:0] DIV_STEPS = 4'd8;

   function automatic color_type dim_color(input color_type c, input logic [7:0] lvl);
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      r = c[23:16] * lvl;
      g = c[15:8] * lvl;
      b = c[7:0] * lvl;
      return {r[15:8], g[15:8], b[15:8]};
   endfunction

   // configuration registers
   logic [MODE_W-1:0]     mode_ff;
   color_type             color_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [DURATION_W-1:0] duration_ff;
   logic [COUNT_W-1:0]    led_count_ff;

   // sequencer state
   logic [2:0]            state_ff, state_in;
   logic [INTERVAL_W-1:0] tsu_ff, tsu_in;
   logic [DURATION_W-1:0] tss_ff, tss_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic                  flash_ff, flash_in;
   logic [7:0]            level_ff, level_in;
   logic                  rising_ff, rising_in;
   logic [ADDR_W-1:0]     wipe_ff, wipe_in;
   logic [7:0]            offset_ff, offset_in;
   logic [7:0]            base_ff, base_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [8:0]            quo_ff, quo_in;
   logic [7:0]            acc_q_ff, acc_q_in;
   logic [CNT_W-1:0]      acc_r_ff, acc_r_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   color_type             fill_ff, fill_in;

   // frame store
   color_type             mem [MAX_LEDS];
   logic [MAX_LEDS-1:0]   valid_ff;
   color_type             rd_data_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   color_type             wr_data;
   logic                  rd_en;

   // staging and output
   logic                  p1_valid_ff;
   logic [ADDR_W-1:0]     p1_idx_ff;
   logic                  p1_last_ff;
   logic                  p1_use_mem_ff;
   logic                  p1_hit_ff;
   color_type             p1_color_ff;
   color_type             p1_pixel;
   logic                  rsp_valid_ff;
   pixel_idx_type         rsp_idx_ff;
   color_type             rsp_color_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  issue;
   logic                  use_mem;
   logic                  last_pixel;
   logic                  fire;
   logic [CNT_W-1:0]      active_n;
   logic [7:0]            level_up;
   logic [7:0]            level_next;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        r_sum;
   logic [CNT_W-1:0]      wipe_next;
   color_type             emit_color;

   assign req_if.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SOLID;
         color_ff     <= '0;
         interval_ff  <= INTERVAL_W'(1000);
         duration_ff  <= '0;
         led_count_ff <= COUNT_W'(MAX_LEDS_DEF);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MODE:     mode_ff      <= csr_wr_data[MODE_W-1:0];
            REG_COLOR:    color_ff     <= csr_wr_data[COLOR_W-1:0];
            REG_INTERVAL: interval_ff  <= csr_wr_data[INTERVAL_W-1:0];
            REG_DURATION: duration_ff  <= csr_wr_data[DURATION_W-1:0];
            REG_COUNT:    led_count_ff <= csr_wr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign issue      = (state_ff == ST_EMIT) && (!p1_valid_ff || out_free);
   assign use_mem    = !(mode_ff == MODE_SOLID || mode_ff == MODE_FLASH ||
                         mode_ff == MODE_BREATHE || mode_ff == MODE_RAINBOW);
   assign last_pixel = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;
   assign fire       = !((duration_ff != '0) && (tss_ff >= duration_ff)) &&
                       (tsu_ff >= interval_ff);
   assign emit_color = (mode_ff == MODE_RAINBOW) ? wheel_color(acc_q_ff + base_ff) : fill_ff;
   assign trial      = {rem_ff, (cnt_ff == DIV_STEPS)};
   assign r_sum      = {1'b0, acc_r_ff} + {1'b0, rem_ff};
   assign wipe_next  = CNT_W'(wipe_ff) + CNT_W'(1);

   always_comb begin
      if (led_count_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (led_count_ff > COUNT_W'(MAX_LEDS)) begin
         active_n = CNT_W'(MAX_LEDS);
      end else begin
         active_n = CNT_W'(led_count_ff);
      end
   end

   always_comb begin
      level_up = level_ff + FADE_STEP;
      if (rising_ff) begin
         level_next = (level_ff > LEVEL_MAX - FADE_STEP) ? LEVEL_MAX : level_up;
      end else begin
         level_next = (level_ff < FADE_STEP) ? 8'd0 : level_ff - FADE_STEP;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tsu_in    = tsu_ff;
      tss_in    = tss_ff;
      n_in      = n_ff;
      flash_in  = flash_ff;
      level_in  = level_ff;
      rising_in = rising_ff;
      wipe_in   = wipe_ff;
      offset_in = offset_ff;
      base_in   = base_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      acc_q_in  = acc_q_ff;
      acc_r_in  = acc_r_ff;
      idx_in    = idx_ff;
      fill_in   = fill_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = emit_color;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               tsu_in = (tsu_ff == '1) ? tsu_ff : tsu_ff + INTERVAL_W'(1);
               if (req_if.restart) begin
                  tss_in = '0;
               end else begin
                  tss_in = (tss_ff == '1) ? tss_ff : tss_ff + DURATION_W'(1);
               end
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (fire) begin
               tsu_in   = '0;
               n_in     = active_n;
               state_in = ST_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            unique case (mode_ff)
               MODE_FLASH: flash_in = !flash_ff;
               MODE_BREATHE: begin
                  level_in = level_next;
                  if (level_next == 8'd0 || level_next == LEVEL_MAX) begin
                     rising_in = !rising_ff;
                  end
               end
               MODE_WIPE: begin
                  wr_en   = 1'b1;
                  wr_addr = wipe_ff;
                  wr_data = color_ff;
                  wipe_in = (wipe_next >= n_ff) ? '0 : wipe_next[ADDR_W-1:0];
               end
               MODE_RAINBOW: begin
                  base_in   = offset_ff;
                  offset_in = offset_ff + 8'd1;
               end
               default: ;
            endcase
            cnt_in   = DIV_STEPS;
            rem_in   = '0;
            quo_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit of 256 / N per cycle
            if (trial >= {1'b0, n_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, n_ff});
               quo_in = {quo_ff[7:0], 1'b1};
            end else begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[7:0], 1'b0};
            end
            unique case (mode_ff)
               MODE_FLASH:   fill_in = flash_ff ? color_ff : '0;
               MODE_BREATHE: fill_in = dim_color(color_ff, level_ff);
               default:      fill_in = color_ff;
            endcase
            if (cnt_ff == '0) begin
               acc_q_in = '0;
               acc_r_in = '0;
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               if (use_mem) begin
                  rd_en = 1'b1;
               end else begin
                  wr_en = 1'b1;
               end
               // advance the i*256/N accumulator by quotient and remainder
               if (r_sum >= {1'b0, n_ff}) begin
                  acc_r_in = CNT_W'(r_sum - {1'b0, n_ff});
                  acc_q_in = acc_q_ff + quo_ff[7:0] + 8'd1;
               end else begin
                  acc_r_in = r_sum[CNT_W-1:0];
                  acc_q_in = acc_q_ff + quo_ff[7:0];
               end
               idx_in = idx_ff + ADDR_W'(1);
               if (last_pixel) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tsu_ff    <= '0;
         tss_ff    <= '0;
         n_ff      <= CNT_W'(1);
         flash_ff  <= 1'b0;
         level_ff  <= LEVEL_MAX;
         rising_ff <= 1'b1;
         wipe_ff   <= '0;
         offset_ff <= '0;
         base_ff   <= '0;
         cnt_ff    <= '0;
         rem_ff    <= '0;
         quo_ff    <= '0;
         acc_q_ff  <= '0;
         acc_r_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         tsu_ff    <= tsu_in;
         tss_ff    <= tss_in;
         n_ff      <= n_in;
         flash_ff  <= flash_in;
         level_ff  <= level_in;
         rising_ff <= rising_in;
         wipe_ff   <= wipe_in;
         offset_ff <= offset_in;
         base_ff   <= base_in;
         cnt_ff    <= cnt_in;
         rem_ff    <= rem_in;
         quo_ff    <= quo_in;
         acc_q_ff  <= acc_q_in;
         acc_r_ff  <= acc_r_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
   end

   // frame store: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // staging register, aligned with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (issue) begin
         p1_valid_ff <= 1'b1;
      end else if (out_free) begin
         p1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p1_idx_ff     <= idx_ff;
         p1_last_ff    <= last_pixel;
         p1_use_mem_ff <= use_mem;
         p1_hit_ff     <= valid_ff[idx_ff];
         p1_color_ff   <= emit_color;
      end
   end

   assign p1_pixel = p1_use_mem_ff ? (p1_hit_ff ? rd_data_ff : '0) : p1_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && p1_valid_ff) begin
         rsp_idx_ff   <= IDX_W'(p1_idx_ff);
         rsp_color_ff <= p1_pixel;
         rsp_last_ff  <= p1_last_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pixel_index = rsp_idx_ff;
   assign rsp_if.pixel_color = rsp_color_ff;
   assign rsp_if.frame_last  = rsp_last_ff;

endmodule
`default_nettype wire

FILE: hdl/lspg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip pattern generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lspg_checker #(
   parameter int MAX_LEDS = lspg_pkg::MAX_LEDS_DEF
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire lspg_pkg::pixel_idx_type rsp_pixel_index,
   input wire lspg_pkg::color_type     rsp_pixel_color,
   input wire logic                    rsp_frame_last
);
   import lspg_pkg::*;

   localparam pixel_idx_type TOP_IDX = IDX_W'(MAX_LEDS - 1);

   // no pixel beat right after reset
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // a tick beat is followed by timer compare in the next cycle, so ready drops
   `ASSERT_RESET(a_tick_gap, clock, reset, (req_valid && req_ready) |=> !req_ready, "back-to-back tick beats")

   // the top LED position always closes a frame
   `ASSERT_RESET(a_last_top, clock, reset, (rsp_valid && !rsp_frame_last) |-> (rsp_pixel_index != TOP_IDX), "top pixel without frame_last")

   // a stalled pixel beat holds
   `ASSERT_RESET(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_index) && $stable(rsp_pixel_color) && $stable(rsp_frame_last)), "stalled rsp beat changed")

endmodule

bind led_strip_pattern_generator_top lspg_checker #(.MAX_LEDS(MAX_LEDS)) u_lspg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_pixel_index (rsp_if.pixel_index),
   .rsp_pixel_color (rsp_if.pixel_color),
   .rsp_frame_last  (rsp_if.frame_last)
);
`default_nettype wire
